### src/r2fft_pkg.sv
// Package for the radix-2 FFT unit: register codes, widths and the twiddle table.
// No dependencies.
`timescale 1ns / 1ps
package r2fft_pkg;
    localparam int DATA_W = 24;
    localparam logic [0:0] REG_INVERSE = 1'd0;
    localparam logic [0:0] REG_SIZE    = 1'd1;
    localparam logic signed [DATA_W-1:0] SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = -24'sh800000;

    // cos(2 pi m / 64), m = 0..16, scaled by 1e9
    function automatic longint quarter_cos(input int m);
        case (m)
            0: return 1000000000; 1: return 995184727; 2: return 980785280;
            3: return 956940336; 4: return 923879533; 5: return 881921264;
            6: return 831469612; 7: return 773010453; 8: return 707106781;
            9: return 634393284; 10: return 555570233; 11: return 471396737;
            12: return 382683432; 13: return 290284677; 14: return 195090322;
            15: return 98017140;
            default: return 0;
        endcase
    endfunction

    // fixed quarter-wave value, rounded half up, +1 saturated
    function automatic longint quarter_fixed(input int m, input int frac);
        longint full;
        longint v;
        full = longint'(1) << frac;
        v = (quarter_cos(m) * full + 500000000) / 1000000000;
        if (v > full - 1) v = full - 1;
        return v;
    endfunction

    // cos(2 pi m / 64) in fixed point
    function automatic longint cos64(input int m, input int frac);
        int mm;
        mm = m & 63;
        if (mm <= 16) return quarter_fixed(mm, frac);
        if (mm <= 32) return -quarter_fixed(32 - mm, frac);
        if (mm <= 48) return -quarter_fixed(mm - 32, frac);
        return quarter_fixed(64 - mm, frac);
    endfunction

    // saturate a 26-bit value to 24 bits
    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [DATA_W+1:0] v);
        if (v > DATA_W'(SAT_MAX)) return SAT_MAX;
        if (v < $signed({{2{1'b1}}, SAT_MIN})) return SAT_MIN;
        return v[DATA_W-1:0];
    endfunction
endpackage

### src/r2fft_bfly.sv
// Butterfly datapath: registered twiddle products, then rounding, add/sub and saturate.
// Depends on r2fft_pkg.
`timescale 1ns / 1ps
module r2fft_bfly #(
    parameter int TW = 16
) (
    input  logic                                aclk,
    input  logic signed [r2fft_pkg::DATA_W-1:0] ar,
    input  logic signed [r2fft_pkg::DATA_W-1:0] ai,
    input  logic signed [r2fft_pkg::DATA_W-1:0] br,
    input  logic signed [r2fft_pkg::DATA_W-1:0] bi,
    input  logic signed [TW-1:0]                c,
    input  logic signed [TW-1:0]                s,
    output logic signed [r2fft_pkg::DATA_W-1:0] xr,
    output logic signed [r2fft_pkg::DATA_W-1:0] xi,
    output logic signed [r2fft_pkg::DATA_W-1:0] yr,
    output logic signed [r2fft_pkg::DATA_W-1:0] yi
);
    import r2fft_pkg::*;
    localparam int PW = DATA_W + TW;
    logic signed [PW-1:0] cbr_reg, sbi_reg, cbi_reg, sbr_reg;
    logic signed [DATA_W-1:0] ar_reg, ai_reg;
    logic signed [PW+1:0] sr, si;
    logic signed [DATA_W+1:0] tr, ti;

    // register the four products and the a operand
    always_ff @(posedge aclk) begin
        cbr_reg <= c * br;
        sbi_reg <= s * bi;
        cbi_reg <= c * bi;
        sbr_reg <= s * br;
        ar_reg  <= ar;
        ai_reg  <= ai;
    end

    // round half up and form both outputs
    always_comb begin
        sr = (PW+2)'(cbr_reg) + (PW+2)'(sbi_reg) + ((PW+2)'(1) <<< (TW-2));
        si = (PW+2)'(cbi_reg) - (PW+2)'(sbr_reg) + ((PW+2)'(1) <<< (TW-2));
        tr = (DATA_W+2)'(sr >>> (TW-1));
        ti = (DATA_W+2)'(si >>> (TW-1));
        xr = sat24((DATA_W+2)'(ar_reg) + tr);
        xi = sat24((DATA_W+2)'(ai_reg) + ti);
        yr = sat24((DATA_W+2)'(ar_reg) - tr);
        yi = sat24((DATA_W+2)'(ai_reg) - ti);
    end
endmodule

### src/radix2_fft_forward_inverse_unit.sv
// Radix-2 DIT FFT unit, forward or inverse, with in-place work memory.
// Depends on r2fft_pkg and r2fft_bfly.
//
//  channel | dir | contents
//  s_      | in  | tdata = sample_re[15:0], sample_im[31:16]
//  m_      | out | tdata = bin_re[23:0], bin_im[47:24]; tlast = last_bin
//  apb     | cfg | 0x0 inverse_mode, 0x4 size_log2
//
// Loads accept a sample whenever s_tvalid is high. The transform runs one butterfly
// at a time through the single memory port pair as read a, read b, multiply,
// write a, write b. Drain reads each bin, then registers it;
// a stalled bin word holds the next read.
// Reset clears control only; no item is taken during transform or drain.
`timescale 1ns / 1ps
module radix2_fft_forward_inverse_unit #(
    parameter int POINTS       = 64,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_re, sample_im
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // bin_re, bin_im
    output logic        m_tlast,   // last_bin
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import r2fft_pkg::*;
    localparam int AW   = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int MAXL = (AW > 6) ? 6 : AW;
    localparam int TW   = TWIDDLE_BITS;
    localparam int FR   = TW - 1;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RDA  = 3'd1;
    localparam logic [2:0] ST_RDB  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_WRA  = 3'd4;
    localparam logic [2:0] ST_WRB  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic       inv_reg;
    logic [2:0] size_reg;
    logic [AW:0] cnt_reg;
    logic [2:0] stage_reg;
    logic [AW-1:0] bfly_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic       rd_pend_reg;
    logic       ovalid_reg;
    logic [47:0] odata_reg;
    logic        olast_reg;

    logic signed [2*DATA_W-1:0] mem [POINTS];
    logic signed [2*DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] ar_reg, ai_reg, xr, xi, yr, yi;
    logic signed [DATA_W-1:0] yr_reg, yi_reg;
    logic signed [TW-1:0] c_reg, s_reg;

    logic [2:0] eff_l;
    logic [AW:0] n_pts;
    logic [AW-1:0] slot, a_idx, b_idx, hl, kk, rd_addr, wr_addr;
    logic [5:0] tw_m;
    logic        we, cfg_wr;
    logic signed [2*DATA_W-1:0] wdata;
    logic signed [TW-1:0] cos_tbl [64];

    // effective length
    always_comb begin
        eff_l = size_reg;
        if (eff_l < 3'd1) eff_l = 3'd1;
        if (eff_l > 3'(MAXL)) eff_l = 3'(MAXL);
        n_pts = (AW+1)'(1) << eff_l;
    end

    // bit-reversed load slot
    always_comb begin
        slot = '0;
        for (int i = 0; i < AW; i++) begin
            if (i < int'(eff_l)) slot[int'(eff_l) - 1 - i] = cnt_reg[i];
        end
    end

    // butterfly addressing: stage s has half length 2^s
    always_comb begin
        hl   = AW'(1) << stage_reg;
        kk   = bfly_reg & (hl - AW'(1));
        a_idx = ((bfly_reg >> stage_reg) << (stage_reg + 3'd1)) | kk;
        b_idx = a_idx | hl;
        tw_m  = 6'(6'(kk) << (3'd5 - stage_reg));
    end

    // constant twiddle table, one cosine per 64th of a turn
    for (genvar g = 0; g < 64; g++) begin : g_tw
        assign cos_tbl[g] = TW'(cos64(g, FR));
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_INVERSE: prdata = {31'd0, inv_reg};
            REG_SIZE:    prdata = {29'd0, size_reg};
            default:     prdata = '0;
        endcase
    end

    // memory port selection
    always_comb begin
        we = 1'b0;
        wr_addr = slot;
        wdata = {DATA_W'($signed(s_tdata[15:0])), DATA_W'($signed(s_tdata[31:16]))};
        if (inv_reg) wdata[DATA_W-1:0] = -DATA_W'($signed(s_tdata[31:16]));
        rd_addr = a_idx;
        case (state_reg)
            ST_LOAD: we = s_tvalid && s_tready;
            ST_RDA:  rd_addr = a_idx;
            ST_RDB:  rd_addr = b_idx;
            ST_WRA: begin
                we = 1'b1; wr_addr = a_idx; wdata = {xr, xi};
            end
            ST_WRB: begin
                we = 1'b1; wr_addr = b_idx; wdata = {yr_reg, yi_reg};
            end
            ST_OUT:  rd_addr = rd_ptr_reg;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) mem[wr_addr] <= wdata;
        rdata_reg <= mem[rd_addr];
    end

    // b operand comes straight from the read register during the multiply cycle
    r2fft_bfly #(.TW(TW)) u_bfly (
        .aclk(aclk), .ar(ar_reg), .ai(ai_reg),
        .br(rdata_reg[2*DATA_W-1:DATA_W]), .bi(rdata_reg[DATA_W-1:0]),
        .c(c_reg), .s(s_reg), .xr(xr), .xi(xi), .yr(yr), .yi(yi)
    );

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

    // output conversion of a read bin
    logic signed [DATA_W+1:0] vr, vi;
    logic [AW-1:0] rnd;
    always_comb begin
        rnd = AW'(n_pts >> 1);
        vr = (DATA_W+2)'($signed(rdata_reg[2*DATA_W-1:DATA_W]));
        vi = (DATA_W+2)'($signed(rdata_reg[DATA_W-1:0]));
        if (inv_reg) begin
            vi = -vi;
            vr = (vr + $signed((DATA_W+2)'(rnd))) >>> eff_l;
            vi = (vi + $signed((DATA_W+2)'(rnd))) >>> eff_l;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RDB) begin
            ar_reg <= rdata_reg[2*DATA_W-1:DATA_W];
            ai_reg <= rdata_reg[DATA_W-1:0];
            c_reg  <= cos_tbl[tw_m];
            s_reg  <= cos_tbl[tw_m + 6'd48];
        end
        if (state_reg == ST_WRA) begin
            yr_reg <= yr;
            yi_reg <= yi;
        end
        if (rd_pend_reg) odata_reg <= {sat24(vi), sat24(vr)};
    end

    // control: register writes, load, butterfly sequencing, drain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD; inv_reg <= 1'b0; size_reg <= 3'd6;
            cnt_reg <= '0; stage_reg <= '0; bfly_reg <= '0; rd_ptr_reg <= '0;
            rd_pend_reg <= 1'b0; ovalid_reg <= 1'b0; olast_reg <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_INVERSE) inv_reg <= pwdata[0];
            if (cfg_wr && paddr[2] == REG_SIZE) begin
                size_reg <= pwdata[2:0];
                cnt_reg <= '0;
            end
            if (m_tvalid && m_tready) ovalid_reg <= 1'b0;
            case (state_reg)
                ST_LOAD: if (s_tvalid) begin
                    if (cnt_reg + 1'b1 == n_pts) begin
                        cnt_reg <= '0; stage_reg <= '0; bfly_reg <= '0;
                        state_reg <= ST_RDA;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_RDA: state_reg <= ST_RDB;
                ST_RDB: state_reg <= ST_MUL;
                ST_MUL: state_reg <= ST_WRA;
                ST_WRA: state_reg <= ST_WRB;
                ST_WRB: begin
                    state_reg <= ST_RDA;
                    if ((AW+1)'(bfly_reg) + 1'b1 == (n_pts >> 1)) begin
                        bfly_reg <= '0;
                        if (stage_reg + 3'd1 == eff_l) begin
                            state_reg <= ST_OUT; rd_ptr_reg <= '0;
                        end else begin
                            stage_reg <= stage_reg + 3'd1;
                        end
                    end else begin
                        bfly_reg <= bfly_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    // one read in flight fills the output register
                    if (rd_pend_reg) begin
                        rd_pend_reg <= 1'b0;
                        ovalid_reg  <= 1'b1;
                        olast_reg   <= ((AW+1)'(rd_ptr_reg) + 1'b1 == n_pts);
                        if ((AW+1)'(rd_ptr_reg) + 1'b1 == n_pts) state_reg <= ST_LOAD;
                        else rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    end else if (!ovalid_reg || m_tready) begin
                        rd_pend_reg <= 1'b1;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_load_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid && $past(state_reg) == ST_OUT && state_reg != ST_LOAD))
        else $error("load during drain");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output dropped");
    a_pend_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> state_reg == ST_OUT)
        else $error("read pending outside drain");
`endif
endmodule

### test/r2fft_scoreboard.sv
// Scoreboard for the radix-2 FFT unit: follows register writes and sample words,
// computes the expected bins and checks every bin word. Depends on r2fft_pkg.
`timescale 1ns / 1ps
module r2fft_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_re, sample_im
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // bin_re, bin_im
    input  logic        m_tlast,   // last_bin
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    import r2fft_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     last;
    } bin_t;

    // cos(2 pi m / 64), m = 0..16, in units of 1e-9
    localparam longint COS_NANO [17] = '{
        1000000000, 995184727, 980785280, 956940336, 923879533,
        881921264, 831469612, 773010453, 707106781, 634393284,
        555570233, 471396737, 382683432, 290284677, 195090322,
        98017140, 0
    };

    bin_t                     bins_due[$];
    logic                     inverse;
    logic [2:0]               size_code;
    logic signed [DATA_W-1:0] mem_re [64];
    logic signed [DATA_W-1:0] mem_im [64];
    int                       loaded;
    int                       fails;

    function automatic logic signed [DATA_W-1:0] clip24(input longint v);
        if (v > 64'sd8388607) return SAT_MAX;
        if (v < -64'sd8388608) return SAT_MIN;
        return v[DATA_W-1:0];
    endfunction

    // Q1.15 quarter-wave value, half-up rounding, +1 clamped
    function automatic longint quarter_q15(input int m);
        longint v;
        v = (COS_NANO[m] * 32768 + 500000000) / 1000000000;
        return (v > 32767) ? 32767 : v;
    endfunction

    function automatic longint twiddle_cos(input int m);
        int k;
        k = m & 63;
        if (k <= 16) return quarter_q15(k);
        if (k <= 32) return -quarter_q15(32 - k);
        if (k <= 48) return -quarter_q15(k - 32);
        return quarter_q15(64 - k);
    endfunction

    function automatic int active_log2(input logic [2:0] code);
        if (code < 3'd1) return 1;
        if (code > 3'd6) return 6;
        return int'(code);
    endfunction

    function automatic int reverse_bits(input int v, input int nbits);
        int r;
        r = 0;
        for (int i = 0; i < nbits; i++) r = (r << 1) | ((v >> i) & 1);
        return r;
    endfunction

    // in-place butterflies over the loaded frame, then queue the bins
    task automatic transform_frame(input int lg);
        int     n;
        int     a;
        int     b;
        longint c;
        longint s;
        longint tr;
        longint ti;
        longint ar;
        longint ai;
        longint vr;
        longint vi;
        bin_t   bn;
        n = 1 << lg;
        for (int len = 2; len <= n; len = len << 1) begin
            for (int base = 0; base < n; base += len) begin
                for (int k = 0; k < len / 2; k++) begin
                    a  = base + k;
                    b  = a + len / 2;
                    c  = twiddle_cos(k * (64 / len));
                    s  = twiddle_cos(k * (64 / len) + 48);
                    tr = (c * longint'(mem_re[b]) + s * longint'(mem_im[b]) + 16384) >>> 15;
                    ti = (c * longint'(mem_im[b]) - s * longint'(mem_re[b]) + 16384) >>> 15;
                    ar = mem_re[a];
                    ai = mem_im[a];
                    mem_re[a] = clip24(ar + tr);
                    mem_im[a] = clip24(ai + ti);
                    mem_re[b] = clip24(ar - tr);
                    mem_im[b] = clip24(ai - ti);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            vr = mem_re[i];
            vi = mem_im[i];
            if (inverse) begin
                vr = (vr + n / 2) >>> lg;
                vi = (-vi + n / 2) >>> lg;
            end
            bn.re   = clip24(vr);
            bn.im   = clip24(vi);
            bn.last = (i == n - 1);
            bins_due.push_back(bn);
        end
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] bin mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        fails++;
    endtask

    always @(posedge aclk) begin
        int     lg;
        longint sre;
        longint sim;
        bin_t   want;
        if (!aresetn) begin
            inverse   = 1'b0;
            size_code = 3'd6;
            loaded    = 0;
            fails     = 0;
            bins_due.delete();
        end else begin
            // follow register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SIZE) begin
                    size_code = pwdata[2:0];
                    loaded    = 0;
                end else begin
                    inverse = pwdata[0];
                end
            end
            // load a sample word, transform when the frame is complete
            if (s_tvalid && s_tready) begin
                lg  = active_log2(size_code);
                if (loaded >= (1 << lg)) loaded = 0;
                sre = longint'($signed(s_tdata[15:0]));
                sim = longint'($signed(s_tdata[31:16]));
                if (inverse) sim = -sim;
                mem_re[reverse_bits(loaded, lg)] = clip24(sre);
                mem_im[reverse_bits(loaded, lg)] = clip24(sim);
                loaded++;
                if (loaded == (1 << lg)) begin
                    loaded = 0;
                    transform_frame(lg);
                end
            end
            // check a bin word against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (bins_due.size() == 0) begin
                    $display("[%0t] bin word with no expectation pending", $time);
                    fails++;
                end else begin
                    want = bins_due.pop_front();
                    if (m_tdata[23:0] !== want.re)
                        report_mismatch("bin_re", want.re, $signed(m_tdata[23:0]));
                    if (m_tdata[47:24] !== want.im)
                        report_mismatch("bin_im", want.im, $signed(m_tdata[47:24]));
                    if (m_tlast !== want.last)
                        report_mismatch("last_bin", want.last, m_tlast);
                end
            end
        end
        errors  <= fails;
        pending <= bins_due.size();
    end
endmodule

### test/tb_radix2_fft_forward_inverse_unit.sv
// Top testbench for the radix-2 FFT unit: clock, reset, register writes, sample
// stimulus and bin-side stalls. Depends on r2fft_pkg, the unit and r2fft_scoreboard.
`timescale 1ns / 1ps
module tb_radix2_fft_forward_inverse_unit;
    import r2fft_pkg::*;

    localparam int RANDOM_ITEMS = 120;
    localparam int MAX_CYCLES   = 1000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // sample_re, sample_im
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // bin_re, bin_im
    logic        m_tlast;         // last_bin
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          hold_left = 0;
    bit          hold_req = 1'b0;
    bit          steady = 1'b0;
    int          items_sent;
    int          bins_made;

    radix2_fft_forward_inverse_unit uut (.*);

    r2fft_scoreboard checker_i (.*);

    always #5 aclk = ~aclk;

    // cycle budget
    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // bin side: random stalls, one long hold-off on request
    always @(posedge aclk) begin
        int r;
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        r = $urandom_range(0, 99);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (steady || r < 70) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            if (r > 96) hold_left = $urandom_range(8, 40);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic [15:0] re, input logic [15:0] im);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // send one frame; style picks full-range, small or extreme content
    task automatic send_frame(input int n, input int style);
        logic [15:0] re;
        logic [15:0] im;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: begin
                    re = $urandom;
                    im = $urandom;
                end
                1: begin
                    re = 16'($signed($urandom_range(0, 511)) - 256);
                    im = 16'($signed($urandom_range(0, 511)) - 256);
                end
                default: begin
                    re = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    im = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                end
            endcase
            send_word(re, im);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait out every pending bin, then let the unit settle
    task automatic drain();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic int frame_len(input int code);
        if (code < 1) return 2;
        if (code > 6) return 64;
        return 1 << code;
    endfunction

    initial begin
        int inv;
        int code;
        int frames;
        int big_frames;
        repeat (9) @(posedge aclk);
        aresetn    <= 1'b1;
        items_sent = 0;
        bins_made  = 0;
        big_frames = 0;
        @(posedge aclk);

        // directed: two-point frames with extreme samples, both directions
        for (int d = 0; d < 2; d++) begin
            reg_write(REG_INVERSE, d);
            reg_write(REG_SIZE, (d == 0) ? 1 : 0);
            send_word(16'h8000, 16'h8000); send_word(16'h8000, 16'h8000);
            send_word(16'h7FFF, 16'h7FFF); send_word(16'h7FFF, 16'h7FFF);
            send_word(16'h7FFF, 16'h8000); send_word(16'h8000, 16'h7FFF);
            send_word(16'h0000, 16'h0000); send_word(16'h0001, 16'hFFFF);
            s_tvalid <= 1'b0;
            drain();
        end
        // directed: four-point frame hits the minus-j twiddle, then an aborted frame
        reg_write(REG_INVERSE, 0);
        reg_write(REG_SIZE, 2);
        send_word(16'h7FFF, 16'h0000); send_word(16'h0000, 16'h7FFF);
        send_word(16'h8000, 16'h0000); send_word(16'h0000, 16'h8000);
        send_word(16'h1234, 16'hEDCB);
        s_tvalid <= 1'b0;
        drain();
        items_sent = 0;

        // random phases; the first uses the largest size code, the second sends
        // several short frames into a long hold-off so the input stalls
        for (int ph = 0; items_sent < RANDOM_ITEMS || bins_made < 48; ph++) begin
            if (ph == 0) begin
                inv  = 1;
                code = 7;
            end else if (ph == 1) begin
                inv  = $urandom_range(0, 1);
                code = 3;
            end else begin
                inv  = $urandom_range(0, 1);
                code = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 4)
                     : $urandom_range(0, 7);
                if (frame_len(code) == 64 && big_frames >= 3) code = 3;
            end
            steady = ($urandom_range(0, 3) == 0);
            reg_write(REG_INVERSE, inv);
            reg_write(REG_SIZE, code);
            frames = (frame_len(code) == 64) ? 1 : (ph == 1) ? 3 : $urandom_range(1, 3);
            if (ph == 1) hold_req = 1'b1;
            for (int f = 0; f < frames; f++) begin
                send_frame(frame_len(code), $urandom_range(0, 9) < 6 ? 1
                           : ($urandom_range(0, 4) == 0 ? 2 : 0));
                bins_made += frame_len(code);
                if (frame_len(code) == 64) big_frames++;
            end
            // occasionally leave a broken frame for the next size write to abort
            if ($urandom_range(0, 4) == 0)
                send_frame($urandom_range(1, frame_len(code) - 1), 0);
            drain();
        end

        steady = 1'b0;
        drain();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
